// File: hdl/rv32_integer_execute_unit_defines.svh
// assertion macros used by the execute unit
// no dependencies; included by the execute unit module, which checks its own logic
`ifndef RV32_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define RV32_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RV32IE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RV32IE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RV32IE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RV32IE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/rv32ie_pkg.sv
// shared constants, opcodes and types of the execute unit
// no dependencies
package rv32ie_pkg;
    localparam int IMEM_DEPTH     = 16384;
    localparam int PC_W           = 14;
    localparam int DMEM_DEPTH_DEF = 65536;
    localparam int XLEN           = 32;
    localparam int RF_DEPTH       = 32;
    localparam int RF_AW          = 5;

    localparam logic [6:0] OPC_IO     = 7'b0001011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [6:0] F7_MULDIV  = 7'b0000001;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;

    typedef struct packed {
        logic            start;
        logic [XLEN-1:0] dividend;
        logic [XLEN-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] quot;
    } t_div_rsp;
endpackage

// File: hdl/rv32ie_if.sv
// stream interfaces for instruction beats in and result beats out
// depends on rv32ie_pkg
interface rv32ie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr;
    logic [7:0]  in_byte;
    modport source (output valid, output instr, output in_byte, input ready);
    modport sink   (input valid, input instr, input in_byte, output ready);
endinterface

interface rv32ie_out_if;
    logic                         valid;
    logic                         ready;
    logic [rv32ie_pkg::PC_W-1:0]  next_pc;
    logic                         out_valid;
    logic [7:0]                   out_byte;
    logic                         illegal;
    modport source (output valid, output next_pc, output out_valid, output out_byte,
                    output illegal, input ready);
    modport sink   (input valid, input next_pc, input out_valid, input out_byte,
                    input illegal, output ready);
endinterface

// File: hdl/rv32ie_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rv32ie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/rv32ie_div.sv
// iterative signed divider, one quotient bit per cycle
// depends on rv32ie_pkg
module rv32ie_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rv32ie_pkg::t_div_req i_req,
    output rv32ie_pkg::t_div_rsp o_rsp
);
    import rv32ie_pkg::*;

    logic [XLEN-1:0] r_rem, r_quot, r_div;
    logic [5:0]      r_cnt;
    logic            r_busy, r_done, r_neg, r_zero;
    logic [XLEN:0]   w_shift, w_diff;
    logic [XLEN-1:0] w_mag_a, w_mag_b;

    assign w_mag_a = i_req.dividend[XLEN-1] ? (~i_req.dividend + 32'd1) : i_req.dividend;
    assign w_mag_b = i_req.divisor[XLEN-1]  ? (~i_req.divisor + 32'd1)  : i_req.divisor;
    assign w_shift = {r_rem, r_quot[XLEN-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring step on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= w_mag_a;
            r_div  <= w_mag_b;
            r_neg  <= i_req.dividend[XLEN-1] ^ i_req.divisor[XLEN-1];
            r_zero <= (i_req.divisor == '0);
        end else if (r_busy) begin
            if (!w_diff[XLEN]) begin
                r_rem <= w_diff[XLEN-1:0];
            end else begin
                r_rem <= w_shift[XLEN-1:0];
            end
            r_quot <= {r_quot[XLEN-2:0], ~w_diff[XLEN]};
        end
    end

    // sign fix-up, divide by zero gives all ones
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_zero ? '1 : (r_neg ? (~r_quot + 32'd1) : r_quot);
endmodule

// File: hdl/rv32_integer_execute_unit.sv
// states: accept, read rs1, read rs2, execute, a memory state for loads or a
// divide state for div, write-back; one instruction at a time, paced by the
// single read port of the register file ram and the serial divider
// reset: pc cleared, register file reads zero through per-entry valid bits,
// no clearing pass; data memory holds garbage until written
module rv32_integer_execute_unit #(
    parameter int DMEM_DEPTH = rv32ie_pkg::DMEM_DEPTH_DEF  // power of two
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rv32ie_in_if.sink     i_in,
    rv32ie_out_if.source  o_out
);
    import rv32ie_pkg::*;

    localparam int DA_W = $clog2(DMEM_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_A    = 7'b0000010,
        S_B    = 7'b0000100,
        S_EX   = 7'b0001000,
        S_MEM  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_WB   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [31:0]     r_instr;
    logic [7:0]      r_in_byte;
    logic [XLEN-1:0] r_a, r_b, r_wd, n_wd;
    logic            r_we, n_we;
    logic [PC_W-1:0] r_pc, r_npc, n_npc;
    logic            r_obv, n_obv, r_ill, n_ill;
    logic [7:0]      r_oby, n_oby;
    logic [RF_DEPTH-1:0] r_rf_vld;
    logic            r_ov;
    logic [PC_W-1:0] r_o_npc;
    logic            r_o_obv, r_o_ill;
    logic [7:0]      r_o_oby;

    logic [RF_AW-1:0] w_rf_raddr;
    logic [XLEN-1:0]  w_rf_rdata;
    logic             w_rf_we;
    logic [DA_W-1:0]  w_dm_addr;
    logic [XLEN-1:0]  w_dm_rdata;
    logic             w_dm_we;
    logic [XLEN-1:0]  w_ld;
    logic             w_go_load, w_go_div, w_wb_fire;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    // instruction fields
    logic [6:0]       w_opc, w_f7;
    logic [2:0]       w_f3;
    logic [RF_AW-1:0] w_rd, w_rs1, w_rs2;
    logic [XLEN-1:0]  w_immi, w_imms, w_immj, w_immb, w_pcb, w_link, w_addr;
    logic [PC_W:0]    w_pc_inc;
    logic             w_lt_s;

    assign w_opc = r_instr[6:0];
    assign w_f3  = r_instr[14:12];
    assign w_f7  = r_instr[31:25];
    assign w_rd  = r_instr[11:7];
    assign w_rs1 = r_instr[19:15];
    assign w_rs2 = r_instr[24:20];
    assign w_immi = {{20{r_instr[31]}}, r_instr[31:20]};
    assign w_imms = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};
    assign w_immj = {{11{r_instr[31]}}, r_instr[31], r_instr[19:12], r_instr[20],
                     r_instr[30:21], 1'b0};
    assign w_immb = {{19{r_instr[31]}}, r_instr[31], r_instr[7], r_instr[30:25],
                     r_instr[11:8], 1'b0};
    assign w_pcb    = {16'd0, r_pc, 2'b00};
    assign w_pc_inc = {1'b0, r_pc} + 15'd1;
    assign w_link   = {15'd0, w_pc_inc, 2'b00};
    assign w_lt_s   = $signed(r_a) < $signed(r_b);
    assign w_addr   = r_a + ((w_opc == OPC_STORE) ? w_imms : w_immi);
    assign w_dm_addr = w_addr[DA_W+1:2];

    // register file read address: rs1 at accept, then rs2 or rd for io read
    always_comb begin
        if (r_state == S_IDLE) begin
            w_rf_raddr = i_in.instr[19:15];
        end else if (w_opc == OPC_IO && !r_instr[12]) begin
            w_rf_raddr = w_rd;
        end else begin
            w_rf_raddr = w_rs2;
        end
    end

    rv32ie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (w_rd),
        .i_wdata (r_wd),
        .i_raddr (w_rf_raddr),
        .o_rdata (w_rf_rdata)
    );

    rv32ie_ram #(.WIDTH(XLEN), .DEPTH(DMEM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (w_dm_we),
        .i_waddr (w_dm_addr),
        .i_wdata (n_wd),
        .i_raddr (w_dm_addr),
        .o_rdata (w_dm_rdata)
    );

    rv32ie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // execute decode
    always_comb begin
        n_wd      = '0;
        n_we      = 1'b0;
        n_npc     = w_pc_inc[PC_W-1:0];
        n_obv     = 1'b0;
        n_oby     = '0;
        n_ill     = 1'b0;
        w_go_load = 1'b0;
        w_go_div  = 1'b0;
        w_dm_we   = 1'b0;
        unique case (w_opc)
            OPC_IO: begin
                if (!r_instr[12]) begin
                    n_wd = {r_b[31:8], r_in_byte};
                    n_we = 1'b1;
                end else begin
                    n_obv = 1'b1;
                    n_oby = r_a[7:0];
                end
            end
            OPC_LUI: begin
                n_wd = {r_instr[31:12], 12'd0};
                n_we = 1'b1;
            end
            OPC_AUIPC: begin
                n_wd = {r_instr[31:12], 12'd0} + w_pcb;
                n_we = 1'b1;
            end
            OPC_JAL: begin
                n_wd  = w_link;
                n_we  = 1'b1;
                n_npc = 14'(((w_pcb + w_immj) >> 2));
            end
            OPC_JALR: begin
                if (w_f3 != F3_ADD) begin
                    n_ill = 1'b1;
                end else begin
                    n_wd  = w_link;
                    n_we  = 1'b1;
                    n_npc = 14'(((r_a + w_immi) >> 2));
                end
            end
            OPC_BRANCH: begin
                case (w_f3)
                    F3_BEQ:  if (r_a == r_b) n_npc = 14'(((w_pcb + w_immb) >> 2));
                    F3_BNE:  if (r_a != r_b) n_npc = 14'(((w_pcb + w_immb) >> 2));
                    F3_BLT:  if (w_lt_s)     n_npc = 14'(((w_pcb + w_immb) >> 2));
                    F3_BGE:  if (!w_lt_s)    n_npc = 14'(((w_pcb + w_immb) >> 2));
                    F3_BLTU: if (r_a < r_b)  n_npc = 14'(((w_pcb + w_immb) >> 2));
                    F3_BGEU: if (r_a >= r_b) n_npc = 14'(((w_pcb + w_immb) >> 2));
                    default: n_ill = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                case (w_f3)
                    F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: w_go_load = 1'b1;
                    default: n_ill = 1'b1;
                endcase
            end
            OPC_STORE: begin
                case (w_f3)
                    F3_LB: begin n_wd = {24'd0, r_b[7:0]};  w_dm_we = (r_state == S_EX); end
                    F3_LH: begin n_wd = {16'd0, r_b[15:0]}; w_dm_we = (r_state == S_EX); end
                    F3_LW: begin n_wd = r_b;                w_dm_we = (r_state == S_EX); end
                    default: n_ill = 1'b1;
                endcase
            end
            OPC_OPIMM: begin
                n_we = 1'b1;
                case (w_f3)
                    F3_ADD:  n_wd = r_a + w_immi;
                    F3_SLL:  n_wd = r_a << w_immi[4:0];
                    F3_SLT:  n_wd = {31'd0, $signed(r_a) < $signed(w_immi)};
                    F3_SLTU: n_wd = {31'd0, r_a < w_immi};
                    F3_XOR:  n_wd = r_a ^ w_immi;
                    F3_SRL:  n_wd = r_a >> w_immi[4:0];
                    F3_OR:   n_wd = r_a | w_immi;
                    default: n_wd = r_a & w_immi;
                endcase
            end
            OPC_OP: begin
                n_we = 1'b1;
                if (w_f3 == F3_ADD && w_f7 == F7_BASE)        n_wd = r_a + r_b;
                else if (w_f3 == F3_ADD && w_f7 == F7_ALT)    n_wd = r_a - r_b;
                else if (w_f3 == F3_ADD && w_f7 == F7_MULDIV) n_wd = 32'(r_a * r_b);
                else if (w_f3 == F3_XOR && w_f7 == F7_MULDIV) begin
                    n_we     = 1'b0;
                    w_go_div = 1'b1;
                end
                else if (w_f3 == F3_SLL && w_f7 == F7_BASE)   n_wd = r_a << r_b[4:0];
                else if (w_f3 == F3_SLTU && w_f7 == F7_BASE)  n_wd = {31'd0, r_a < r_b};
                else if (w_f3 == F3_XOR && w_f7 == F7_BASE)   n_wd = r_a ^ r_b;
                else if (w_f3 == F3_SRL && w_f7 == F7_BASE)   n_wd = r_a >> r_b[4:0];
                else if (w_f3 == F3_OR)                       n_wd = r_a | r_b;
                else if (w_f3 == F3_AND)                      n_wd = r_a & r_b;
                else begin
                    n_we  = 1'b0;
                    n_ill = 1'b1;
                end
            end
            default: n_ill = 1'b1;
        endcase
    end

    assign w_div_req.start    = (r_state == S_EX) && w_go_div;
    assign w_div_req.dividend = r_a;
    assign w_div_req.divisor  = r_b;

    // load formatting
    always_comb begin
        case (w_f3)
            F3_LB:   w_ld = {{24{w_dm_rdata[7]}}, w_dm_rdata[7:0]};
            F3_LH:   w_ld = {{16{w_dm_rdata[15]}}, w_dm_rdata[15:0]};
            F3_LBU:  w_ld = {24'd0, w_dm_rdata[7:0]};
            F3_LHU:  w_ld = {16'd0, w_dm_rdata[15:0]};
            default: w_ld = w_dm_rdata;
        endcase
    end

    assign w_wb_fire = (r_state == S_WB) && (!r_ov || o_out.ready);
    assign w_rf_we   = w_wb_fire && r_we && (w_rd != '0);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_A;
            S_A:    n_state = S_B;
            S_B:    n_state = S_EX;
            S_EX: begin
                if (w_go_load)     n_state = S_MEM;
                else if (w_go_div) n_state = S_DIV;
                else               n_state = S_WB;
            end
            S_MEM:  n_state = S_WB;
            S_DIV:  if (w_div_rsp.done) n_state = S_WB;
            S_WB:   if (w_wb_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_rf_vld <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_rf_we) begin
                r_rf_vld[w_rd] <= 1'b1;
            end
            if (w_wb_fire) begin
                r_pc <= r_npc;
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_instr   <= i_in.instr;
            r_in_byte <= i_in.in_byte;
        end
        if (r_state == S_A) begin
            r_a <= r_rf_vld[w_rs1] ? w_rf_rdata : '0;
        end
        if (r_state == S_B) begin
            r_b <= r_rf_vld[w_rf_raddr] ? w_rf_rdata : '0;
        end
        if (r_state == S_EX) begin
            r_wd  <= n_wd;
            r_we  <= n_we;
            r_npc <= n_npc;
            r_obv <= n_obv;
            r_oby <= n_oby;
            r_ill <= n_ill;
        end
        if (r_state == S_MEM) begin
            r_wd <= w_ld;
            r_we <= 1'b1;
        end
        if (r_state == S_DIV && w_div_rsp.done) begin
            r_wd <= w_div_rsp.quot;
            r_we <= 1'b1;
        end
        if (w_wb_fire) begin
            r_o_npc <= r_npc;
            r_o_obv <= r_obv;
            r_o_oby <= r_oby;
            r_o_ill <= r_ill;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.next_pc   = r_o_npc;
    assign o_out.out_valid = r_o_obv;
    assign o_out.out_byte  = r_o_oby;
    assign o_out.illegal   = r_o_ill;

    `include "rv32_integer_execute_unit_defines.svh"

    `RV32IE_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV)
    `RV32IE_ASSERT_IMP(a_no_x0_write, i_clk, i_rst_n, w_rf_we, w_rd != '0 && !r_ill)
    `RV32IE_ASSERT_IMP(a_store_in_ex, i_clk, i_rst_n, w_dm_we,
                       r_state == S_EX && w_opc == OPC_STORE)
    `RV32IE_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_A)
endmodule

// File: tb/sv/rv32_integer_execute_unit_test.sv
// self-checking testbench of the rv32 integer execute unit: instruction beats in, result beats out
// depends on rv32ie_pkg, rv32ie_if and rv32_integer_execute_unit from the hdl sources
`timescale 1ns / 100ps

module rv32_integer_execute_unit_test;
    import rv32ie_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam logic [6:0] OPC_FLW   = 7'b0000111;
    localparam logic [6:0] OPC_FSW   = 7'b0100111;
    localparam logic [6:0] OPC_FMADD = 7'b1000011;
    localparam logic [6:0] OPC_FOP   = 7'b1010011;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            out_valid;
        logic [7:0]      out_byte;
        logic            illegal;
    } t_exec_result;

    typedef struct packed {
        logic [31:0] instr;
        logic [7:0]  in_byte;
    } t_instr_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rv32ie_in_if  in_ch ();
    rv32ie_out_if out_ch ();

    rv32_integer_execute_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow architectural state
    logic [31:0]     shadow_regs [RF_DEPTH];
    logic [31:0]     shadow_dmem [int unsigned];
    logic [PC_W-1:0] shadow_pc;

    t_instr_beat  pending_beats [$];
    t_exec_result expected_results [$];
    logic [11:0]  stored_offsets [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int cycles = 0;
    bit in_took = 1'b0;

    always #5 i_clk = ~i_clk;

    // instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    // store addressed from x0, remembered so that later loads only read written words
    function automatic logic [31:0] store_from_zero(logic [2:0] f3, logic [4:0] rs2,
                                                    logic [11:0] imm);
        if (f3 <= F3_LW)
            stored_offsets.push_back(imm);
        return enc_s(imm, rs2, 5'd0, f3);
    endfunction

    function automatic logic [31:0] load_from_zero(logic [2:0] f3, logic [4:0] rd);
        logic [11:0] imm;
        imm = stored_offsets[$urandom_range(stored_offsets.size() - 1)];
        return enc_i(imm, 5'd0, f3, rd, OPC_LOAD);
    endfunction

    function automatic void write_reg(logic [4:0] rd, logic [31:0] v);
        if (rd != 5'd0)
            shadow_regs[rd] = v;
    endfunction

    function automatic logic [31:0] read_word(int unsigned idx);
        if (shadow_dmem.exists(idx))
            return shadow_dmem[idx];
        return 32'd0;
    endfunction

    // executes one instruction on the shadow state and gives its result beat
    function automatic t_exec_result execute_instr(logic [31:0] ins, logic [7:0] inb);
        t_exec_result r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] immi;
        logic [31:0] imms;
        logic [31:0] off;
        logic [31:0] sum;
        logic [31:0] pc_bytes;
        logic [31:0] link;
        logic [31:0] word;
        logic [31:0] q;
        int unsigned idx;
        bit take;
        opc = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        rd = ins[11:7];
        a = shadow_regs[ins[19:15]];
        b = shadow_regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        pc_bytes = {16'd0, shadow_pc, 2'b00};
        link = (32'(shadow_pc) + 32'd1) << 2;
        r = '0;
        r.next_pc = shadow_pc + 1'b1;
        case (opc)
            OPC_IO: begin
                if (!ins[12]) begin
                    write_reg(rd, {shadow_regs[rd][31:8], inb});
                end else begin
                    r.out_valid = 1'b1;
                    r.out_byte = a[7:0];
                end
            end
            OPC_LUI: write_reg(rd, {ins[31:12], 12'd0});
            OPC_AUIPC: write_reg(rd, {ins[31:12], 12'd0} + pc_bytes);
            OPC_JAL: begin
                off = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                write_reg(rd, link);
                sum = pc_bytes + off;
                r.next_pc = sum[PC_W+1:2];
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    r.illegal = 1'b1;
                end else begin
                    write_reg(rd, link);
                    sum = a + immi;
                    r.next_pc = sum[PC_W+1:2];
                end
            end
            OPC_BRANCH: begin
                off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                take = 1'b0;
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = ($signed(a) >= $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: r.illegal = 1'b1;
                endcase
                if (take) begin
                    sum = pc_bytes + off;
                    r.next_pc = sum[PC_W+1:2];
                end
            end
            OPC_LOAD: begin
                sum = a + immi;
                word = read_word(int'(sum[17:2]));
                case (f3)
                    F3_LB:   write_reg(rd, {{24{word[7]}}, word[7:0]});
                    F3_LH:   write_reg(rd, {{16{word[15]}}, word[15:0]});
                    F3_LW:   write_reg(rd, word);
                    F3_LBU:  write_reg(rd, {24'd0, word[7:0]});
                    F3_LHU:  write_reg(rd, {16'd0, word[15:0]});
                    default: r.illegal = 1'b1;
                endcase
            end
            OPC_STORE: begin
                sum = a + imms;
                idx = int'(sum[17:2]);
                case (f3)
                    F3_LB:   shadow_dmem[idx] = {24'd0, b[7:0]};
                    F3_LH:   shadow_dmem[idx] = {16'd0, b[15:0]};
                    F3_LW:   shadow_dmem[idx] = b;
                    default: r.illegal = 1'b1;
                endcase
            end
            OPC_OPIMM: begin
                case (f3)
                    F3_ADD:  write_reg(rd, a + immi);
                    F3_SLL:  write_reg(rd, a << immi[4:0]);
                    F3_SLT:  write_reg(rd, {31'd0, $signed(a) < $signed(immi)});
                    F3_SLTU: write_reg(rd, {31'd0, a < immi});
                    F3_XOR:  write_reg(rd, a ^ immi);
                    F3_SRL:  write_reg(rd, a >> immi[4:0]);
                    F3_OR:   write_reg(rd, a | immi);
                    default: write_reg(rd, a & immi);
                endcase
            end
            OPC_OP: begin
                if (f3 == F3_ADD && f7 == F7_BASE) write_reg(rd, a + b);
                else if (f3 == F3_ADD && f7 == F7_ALT) write_reg(rd, a - b);
                else if (f3 == F3_ADD && f7 == F7_MULDIV) write_reg(rd, a * b);
                else if (f3 == F3_XOR && f7 == F7_MULDIV) begin
                    // zero divisor gives all ones, the overflow case gives the dividend
                    if (b == 32'd0) q = 32'hFFFF_FFFF;
                    else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) q = a;
                    else q = $signed(a) / $signed(b);
                    write_reg(rd, q);
                end
                else if (f3 == F3_SLL && f7 == F7_BASE) write_reg(rd, a << b[4:0]);
                else if (f3 == F3_SLTU && f7 == F7_BASE) write_reg(rd, {31'd0, a < b});
                else if (f3 == F3_XOR && f7 == F7_BASE) write_reg(rd, a ^ b);
                else if (f3 == F3_SRL && f7 == F7_BASE) write_reg(rd, a >> b[4:0]);
                else if (f3 == F3_OR) write_reg(rd, a | b);
                else if (f3 == F3_AND) write_reg(rd, a & b);
                else r.illegal = 1'b1;
            end
            default: r.illegal = 1'b1;
        endcase
        shadow_pc = r.next_pc;
        return r;
    endfunction

    // random instruction, mostly well formed with random operands
    function automatic logic [31:0] random_instr();
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [6:0]  f7;
        logic [6:0]  raw_opc;
        logic [6:0]  bad_opc [4];
        int pick;
        rd = 5'($urandom_range(31));
        rs1 = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
        rs2 = 5'($urandom_range(31));
        f3 = 3'($urandom_range(7));
        imm = 12'($urandom);
        bad_opc = '{OPC_FLW, OPC_FSW, OPC_FMADD, OPC_FOP};
        pick = $urandom_range(99);
        if (pick < 22) begin
            return enc_i(imm, rs1, f3, rd, OPC_OPIMM);
        end else if (pick < 44) begin
            case ($urandom_range(5))
                0: f7 = F7_ALT;
                1, 2: f7 = F7_MULDIV;
                3: f7 = 7'($urandom);
                default: f7 = F7_BASE;
            endcase
            return enc_r(f7, rs2, rs1, f3, rd, OPC_OP);
        end else if (pick < 50) begin
            return {20'($urandom), rd, ($urandom_range(1) == 0) ? OPC_LUI : OPC_AUIPC};
        end else if (pick < 56) begin
            return {$urandom_range(15) == 0 ? 7'($urandom) : 7'd0, rs2, rs1,
                    $urandom_range(1) == 1, 7'($urandom), OPC_IO};
        end else if (pick < 64) begin
            return store_from_zero(3'($urandom_range(2)), rs2, imm);
        end else if (pick < 68) begin
            return enc_s(imm, rs2, rs1, f3);
        end else if (pick < 78) begin
            if (stored_offsets.size() == 0)
                return store_from_zero(F3_LW, rs2, imm);
            return load_from_zero(f3, rd);
        end else if (pick < 88) begin
            return enc_b(13'($urandom), rs2, rs1, f3);
        end else if (pick < 92) begin
            return enc_j(21'($urandom), rd);
        end else if (pick < 96) begin
            return enc_i(imm, rs1, ($urandom_range(3) == 0) ? f3 : 3'd0, rd, OPC_JALR);
        end else if (pick < 98) begin
            return {25'($urandom), bad_opc[$urandom_range(3)]};
        end else begin
            // raw word, a load opcode turned into op-imm so no unwritten word is read
            raw_opc = 7'($urandom_range(127));
            if (raw_opc == OPC_LOAD)
                raw_opc = OPC_OPIMM;
            return {25'($urandom), raw_opc};
        end
    endfunction

    task automatic queue_beat(logic [31:0] ins, logic [7:0] inb);
        pending_beats.push_back('{instr: ins, in_byte: inb});
    endtask

    task automatic wait_all_done();
        while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 field, beats_out, got, want);
        mismatches++;
    endtask

    // instruction driver
    always @(negedge i_clk) begin
        t_instr_beat beat;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.instr <= '0;
            in_ch.in_byte <= '0;
        end else if (!in_ch.valid || in_took) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
                beat = pending_beats.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.instr <= beat.instr;
                in_ch.in_byte <= beat.in_byte;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            out_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on accepted instruction beats, check result beats
    always @(posedge i_clk) begin
        t_exec_result want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                expected_results.push_back(execute_instr(in_ch.instr, in_ch.in_byte));
                beats_in++;
            end
            if (out_ch.valid && out_ch.ready) begin
                beats_out++;
                if (expected_results.size() == 0) begin
                    $display("unexpected result beat %0d", beats_out);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.next_pc !== want.next_pc)
                        report("next_pc", 32'(out_ch.next_pc), 32'(want.next_pc));
                    if (out_ch.out_valid !== want.out_valid)
                        report("out_valid", 32'(out_ch.out_valid), 32'(want.out_valid));
                    if (out_ch.out_byte !== want.out_byte)
                        report("out_byte", 32'(out_ch.out_byte), 32'(want.out_byte));
                    if (out_ch.illegal !== want.illegal)
                        report("illegal", 32'(out_ch.illegal), 32'(want.illegal));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rv32_integer_execute_unit_test: errors");
            $finish;
        end
    end

    initial begin
        int phase_idle [4];
        int phase_stall [4];
        logic [2:0] op_f3 [10];
        logic [6:0] op_f7 [10];
        phase_idle = '{0, 69, 0, 14};
        phase_stall = '{0, 0, 69, 14};
        op_f3 = '{F3_ADD, F3_ADD, F3_ADD, F3_XOR, F3_SLL, F3_SLTU, F3_XOR, F3_SRL, F3_OR, F3_AND};
        op_f7 = '{F7_BASE, F7_ALT, F7_MULDIV, F7_MULDIV, F7_BASE, F7_BASE, F7_BASE, F7_BASE,
                  F7_ALT, F7_MULDIV};
        for (int i = 0; i < RF_DEPTH; i++)
            shadow_regs[i] = '0;
        shadow_pc = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every opcode, the special cases
        queue_beat({20'hFFFFF, 5'd1, OPC_LUI}, 8'h00);
        queue_beat(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM), 8'h00);
        queue_beat(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OPC_OPIMM), 8'h00);
        queue_beat({20'h80000, 5'd8, OPC_LUI}, 8'h00);
        queue_beat({20'h12345, 5'd4, OPC_AUIPC}, 8'h00);
        queue_beat(store_from_zero(F3_LW, 5'd2, 12'h000), 8'h00);
        queue_beat(store_from_zero(F3_LB, 5'd2, 12'hFFC), 8'h00);
        queue_beat(store_from_zero(F3_LH, 5'd2, 12'h7FC), 8'h00);
        for (int f = 0; f < 8; f++)
            queue_beat(enc_i(12'h000, 5'd0, 3'(f), 5'd5 + 5'(f), OPC_LOAD), 8'h00);
        queue_beat(enc_i(12'hFFC, 5'd0, F3_LW, 5'd13, OPC_LOAD), 8'h00);
        queue_beat(enc_i(12'h7FC, 5'd0, F3_LH, 5'd14, OPC_LOAD), 8'h00);
        // division by zero and the signed overflow case
        queue_beat(enc_r(F7_MULDIV, 5'd0, 5'd2, F3_XOR, 5'd15, OPC_OP), 8'h00);
        queue_beat(enc_r(F7_MULDIV, 5'd2, 5'd8, F3_XOR, 5'd16, OPC_OP), 8'h00);
        for (int k = 0; k < 10; k++)
            queue_beat(enc_r(op_f7[k], 5'd3, 5'd2, op_f3[k], 5'd17, OPC_OP), 8'h00);
        queue_beat(enc_r(F7_ALT, 5'd3, 5'd2, F3_SLL, 5'd18, OPC_OP), 8'h00);
        queue_beat(enc_i(12'h41F, 5'd2, F3_SRL, 5'd19, OPC_OPIMM), 8'h00);
        queue_beat(enc_i(12'h800, 5'd2, F3_SLT, 5'd20, OPC_OPIMM), 8'h00);
        queue_beat({17'd0, 3'b000, 5'd21, OPC_IO}, 8'hFF);
        queue_beat({17'd0, 3'b000, 5'd0, OPC_IO}, 8'hA5);
        queue_beat({12'd0, 5'd21, 3'b001, 5'd0, OPC_IO}, 8'h00);
        queue_beat(enc_b(13'h1000, 5'd3, 5'd2, F3_BGE), 8'h00);
        queue_beat(enc_b(13'h0FFE, 5'd3, 5'd2, F3_BGEU), 8'h00);
        queue_beat(enc_b(13'h0004, 5'd3, 5'd2, 3'd2), 8'h00);
        queue_beat(enc_j(21'h100000, 5'd22), 8'h00);
        queue_beat(enc_i(12'h7FF, 5'd2, 3'd0, 5'd23, OPC_JALR), 8'h00);
        queue_beat(enc_i(12'h000, 5'd2, 3'd1, 5'd23, OPC_JALR), 8'h00);
        queue_beat({25'h1FFFFFF, OPC_FOP}, 8'h00);
        wait_all_done();

        // random phases with different idling mixes
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                while (pending_beats.size() > 2)
                    @(posedge i_clk);
                queue_beat(random_instr(), 8'($urandom));
                if (p == 0 && n == 40) begin
                    // long receiver hold-off while beats keep coming
                    hold_requests++;
                end
                if (p == 1 && n == 60) begin
                    // sender waits for the pipeline to drain
                    wait_all_done();
                end
            end
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d instruction beats accepted, %0d result beats checked, %0d cycles",
                 beats_in, beats_out, cycles);
        $display("covered all opcodes, illegal encodings and four idling mixes");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("rv32_integer_execute_unit_test: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_results.size());
            $display("rv32_integer_execute_unit_test: errors");
        end
        $finish;
    end

endmodule
